FILE: design/assert_macros.svh
// assertion macros for the rtl, included by object_id_color_hash
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, held off while reset is asserted
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: design/oich_pkg.sv
// constants, types and helpers for the object id color hash
package oich_pkg;

    // default number of mixer rounds
    localparam int unsigned HASH_ROUNDS_DEF = 4;

    // mixer constants
    localparam logic [31:0] V0_START   = 32'h0000_0123;
    localparam logic [31:0] ROUND_STEP = 32'h9e37_79b9;
    localparam logic [31:0] KEY_A      = 32'ha341_316c;
    localparam logic [31:0] KEY_B      = 32'hc801_3ea4;
    localparam logic [31:0] KEY_C      = 32'had90_777d;
    localparam logic [31:0] KEY_D      = 32'h7e95_761e;

    // payload carried down the pipeline
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] c;
        logic        nz;
        logic        fe;
    } pipe_t;

    // running sum after round k (counting from 0), elaborated as a constant
    function automatic logic [31:0] round_sum(input int unsigned k);
        logic [63:0] prod;
        prod = 64'(k + 1) * 64'(ROUND_STEP);
        return prod[31:0];
    endfunction

    // one mixer term: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb)
    function automatic logic [31:0] mix_term(input logic [31:0] x,
                                             input logic [31:0] sum,
                                             input logic [31:0] ka,
                                             input logic [31:0] kb);
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

FILE: design/object_id_color_hash.sv
// object id to color hash: pipelined tea-style mixer over a decoded pixel id
// throughput: one pixel per cycle unless out_ready stalls, each stage after decode holds one half round of the mixer
// stalls back up stage by stage, empty stages keep taking requests
// reset: asynchronous, active low, clears all stage valid bits
`include "assert_macros.svh"

module object_id_color_hash #(
    parameter int unsigned HASH_ROUNDS = oich_pkg::HASH_ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] red_level,
    input  logic [15:0] green_level,
    input  logic [15:0] blue_level,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out,
    output logic        alpha_out,
    output logic        frame_end_out
);

    // decode stage plus two half rounds per round
    localparam int unsigned NSTAGE = 2 * HASH_ROUNDS + 1;
    localparam int unsigned LAST   = NSTAGE - 1;

    oich_pkg::pipe_t stage_reg  [NSTAGE];
    oich_pkg::pipe_t stage_next [NSTAGE];
    logic            valid_reg  [NSTAGE];
    logic            stage_ready[NSTAGE];
    logic [31:0]     id_sum;

    // per stage ready, a stage moves when empty or when its successor moves
    generate
        for (genvar j = 0; j < NSTAGE; j++) begin : g_ready
            if (j == LAST) begin : g_end
                assign stage_ready[j] = !valid_reg[j] || out_ready;
            end
            else begin : g_mid
                assign stage_ready[j] = !valid_reg[j] || stage_ready[j + 1];
            end
        end
    endgenerate

    assign in_ready = stage_ready[0];

    // id decode: (r >> 8) + g + (b << 8)
    always_comb
    begin
        id_sum = 32'(red_level[15:8]) + 32'(green_level) + {8'd0, blue_level, 8'd0};
        stage_next[0].a  = oich_pkg::V0_START;
        stage_next[0].c  = id_sum;
        stage_next[0].nz = (id_sum != 32'd0);
        stage_next[0].fe = frame_end;
    end

    // half round stages
    generate
        for (genvar j = 1; j < NSTAGE; j++) begin : g_half
            localparam int unsigned    RND = (j - 1) / 2;
            localparam logic [31:0]    SUM = oich_pkg::round_sum(RND);
            if (j % 2 == 1) begin : g_upd_a
                always_comb
                begin
                    stage_next[j]   = stage_reg[j - 1];
                    stage_next[j].a = stage_reg[j - 1].a +
                        oich_pkg::mix_term(stage_reg[j - 1].c, SUM,
                                           oich_pkg::KEY_A, oich_pkg::KEY_B);
                end
            end
            else begin : g_upd_c
                always_comb
                begin
                    stage_next[j]   = stage_reg[j - 1];
                    stage_next[j].c = stage_reg[j - 1].c +
                        oich_pkg::mix_term(stage_reg[j - 1].a, SUM,
                                           oich_pkg::KEY_C, oich_pkg::KEY_D);
                end
            end
        end
    endgenerate

    // stage valid bits and payload
    generate
        for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
            logic up_valid;
            if (j == 0) begin : g_src_in
                assign up_valid = in_valid;
            end
            else begin : g_src_stage
                assign up_valid = valid_reg[j - 1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (stage_ready[j])
                begin
                    valid_reg[j] <= up_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[j] && up_valid)
                begin
                    stage_reg[j] <= stage_next[j];
                end
            end
        end
    endgenerate

    // result, zero id gives a blank pixel
    assign out_valid     = valid_reg[LAST];
    assign red_out       = stage_reg[LAST].nz ? stage_reg[LAST].a[15:0]  : 16'd0;
    assign green_out     = stage_reg[LAST].nz ? stage_reg[LAST].a[31:16] : 16'd0;
    assign blue_out      = stage_reg[LAST].nz ? stage_reg[LAST].c[15:0]  : 16'd0;
    assign alpha_out     = stage_reg[LAST].nz;
    assign frame_end_out = stage_reg[LAST].fe;

    // input is held off only when the result side backs up
    `ASSERT_CLK(a_stall_source, !in_ready |-> (out_valid && !out_ready))
    // an accepted request lands in the decode stage
    `ASSERT_CLK(a_accept_fills, (in_valid && in_ready) |=> valid_reg[0])
    // a result that is not taken stays on the port
    `ASSERT_CLK(a_result_holds, (out_valid && !out_ready) |=> out_valid)

endmodule
